// File: sv/two_stream_audio_mixer_limiter_top_macros.svh
`ifndef TWO_STREAM_AUDIO_MIXER_LIMITER_TOP_MACROS_SVH
`define TWO_STREAM_AUDIO_MIXER_LIMITER_TOP_MACROS_SVH

// check a condition at every clock edge out of reset
`define TSAML_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// check a consequence in the cycle after a trigger
`define TSAML_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tsaml_pkg.sv
package tsaml_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 17;
    localparam int GAIN_W    = 17;
    localparam int CODE_W    = 12;
    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int RECOV_SHIFT = 5;

    localparam logic [GAIN_W-1:0] GAIN_ONE    = 17'd65536;
    localparam logic [SUM_W-1:0]  MIX_HIGH    = 17'd16383;
    localparam logic [SUM_W-1:0]  MIX_LOW_MAG = 17'd16384;
    localparam logic signed [SUM_W-1:0] SUM_HIGH  = 17'sd16383;
    localparam logic signed [SUM_W-1:0] VALUE_LOW = -17'sd16384;
    localparam logic [CODE_W-1:0] CODE_BASE   = 12'd1024;

    typedef struct packed {
        logic load;
        logic div_hi_start;
        logic div_lo_start;
        logic div_step;
        logic mul;
        logic recov;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic mode1;
        logic sum_high;
        logic value_low;
        logic div_last;
        logic div_lo;
        logic out_free;
    } t_stat;

endpackage

// File: sv/tsaml_ctrl.sv
module tsaml_ctrl
    import tsaml_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_LOW   = 7'b0010000,
        S_RECOV = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (!i_stat.mode1) begin
                    n_state = S_DONE;
                end else if (i_stat.sum_high) begin
                    o_cmd.div_hi_start = 1'b1;
                    n_state            = S_DIV;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = i_stat.div_lo ? S_RECOV : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LOW;
            end
            S_LOW: begin
                if (i_stat.value_low) begin
                    o_cmd.div_lo_start = 1'b1;
                    n_state            = S_DIV;
                end else begin
                    n_state = S_RECOV;
                end
            end
            S_RECOV: begin
                o_cmd.recov = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/tsaml_dp.sv
`include "two_stream_audio_mixer_limiter_top_macros.svh"

module tsaml_dp
    import tsaml_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic                       i_mode,
    input  logic signed [SAMPLE_W-1:0] i_sample_a,
    input  logic signed [SAMPLE_W-1:0] i_sample_b,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [CODE_W-1:0]          o_dac_code
);

    logic [GAIN_W-1:0]        r_gain,   n_gain;
    logic                     r_out_valid, n_out_valid;
    logic [CNT_W-1:0]         r_cnt,    n_cnt;
    logic                     r_mode,   n_mode;
    logic                     r_div_lo, n_div_lo;
    logic signed [SUM_W-1:0]  r_sum,    n_sum;
    logic signed [SUM_W-1:0]  r_value,  n_value;
    logic [SUM_W-1:0]         r_rem,    n_rem;
    logic [SUM_W-1:0]         r_div,    n_div;
    logic [DIV_STEPS-1:0]     r_quo,    n_quo;
    logic [CODE_W-1:0]        r_code,   n_code;
    logic [CODE_W-1:0]        r_out,    n_out;

    logic [SUM_W:0]           rem_sh;
    logic [SUM_W:0]           rem_sub;
    logic                     rem_ge;
    logic [DIV_STEPS-1:0]     quo_next;
    logic                     sum_neg;
    logic [SUM_W:0]           sum_negx;
    logic [SUM_W-1:0]         sum_mag;
    logic [SUM_W+GAIN_W-1:0]  prod;
    logic [SUM_W-1:0]         prod_q;
    logic [SUM_W:0]           value_negx;
    logic [GAIN_W-1:0]        gain_gap;
    logic [SUM_W-1:0]         value_off;

    assign rem_sh   = {r_rem, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign rem_sub  = rem_sh - {1'b0, r_div};
    assign quo_next = {r_quo[DIV_STEPS-2:0], rem_ge};

    assign sum_neg    = r_sum[SUM_W-1];
    assign sum_negx   = -{r_sum[SUM_W-1], r_sum};
    assign sum_mag    = sum_neg ? sum_negx[SUM_W-1:0] : r_sum;
    assign prod       = (SUM_W+GAIN_W)'(sum_mag) * (SUM_W+GAIN_W)'(r_gain);
    assign prod_q     = prod[SUM_W+15:16];
    assign value_negx = -{r_value[SUM_W-1], r_value};
    assign gain_gap   = GAIN_ONE - r_gain;
    assign value_off  = r_value + $signed(MIX_LOW_MAG);

    assign o_stat.mode1     = r_mode;
    assign o_stat.sum_high  = r_sum > SUM_HIGH;
    assign o_stat.value_low = r_value < VALUE_LOW;
    assign o_stat.div_last  = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_stat.div_lo    = r_div_lo;
    assign o_stat.out_free  = !r_out_valid || i_ready;

    assign o_valid    = r_out_valid;
    assign o_dac_code = r_out;

    always_comb begin
        n_gain      = r_gain;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_div_lo    = r_div_lo;
        n_sum       = r_sum;
        n_value     = r_value;
        n_rem       = r_rem;
        n_div       = r_div;
        n_quo       = r_quo;
        n_code      = r_code;
        n_out       = r_out;

        if (i_cmd.load) begin
            n_mode = i_mode;
            n_sum  = {i_sample_a[SAMPLE_W-1], i_sample_a}
                   + {i_sample_b[SAMPLE_W-1], i_sample_b};
            n_code = {~i_sample_a[SAMPLE_W-1], i_sample_a[SAMPLE_W-2:4]};
        end

        if (i_cmd.div_hi_start) begin
            n_rem    = MIX_HIGH;
            n_div    = r_sum;
            n_cnt    = '0;
            n_div_lo = 1'b0;
        end

        if (i_cmd.div_lo_start) begin
            n_rem    = MIX_LOW_MAG;
            n_div    = value_negx[SUM_W-1:0];
            n_cnt    = '0;
            n_div_lo = 1'b1;
        end

        if (i_cmd.div_step) begin
            n_rem = rem_ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            n_quo = quo_next;
            n_cnt = r_cnt + 1'b1;
            if (o_stat.div_last) begin
                n_gain = {1'b0, quo_next};
                if (r_div_lo) begin
                    n_value = VALUE_LOW;
                end else begin
                    n_sum = SUM_HIGH;
                end
            end
        end

        if (i_cmd.mul) begin
            n_value = sum_neg ? (~prod_q + 1'b1) : prod_q;
        end

        if (i_cmd.recov) begin
            if (r_gain < GAIN_ONE) begin
                n_gain = r_gain + (gain_gap >> RECOV_SHIFT);
            end
            n_code = {1'b0, value_off[14:4]} + CODE_BASE;
        end

        if (i_cmd.emit) begin
            n_out       = r_code;
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_mode   <= n_mode;
        r_div_lo <= n_div_lo;
        r_sum    <= n_sum;
        r_value  <= n_value;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_quo    <= n_quo;
        r_code   <= n_code;
        r_out    <= n_out;
    end

    `TSAML_ASSERT_ALWAYS(a_gain_range, (r_gain != '0) && (r_gain <= GAIN_ONE), "limiter gain out of range")
    `TSAML_ASSERT_NEXT(a_emit_valid, i_cmd.emit, r_out_valid && (r_out == $past(r_code)), "emitted word not presented")
    `TSAML_ASSERT_NEXT(a_mix_code, i_cmd.recov, (r_code >= 12'd1024) && (r_code <= 12'd3071), "mixed code outside window")

endmodule

// File: sv/two_stream_audio_mixer_limiter_top.sv
// Two-stream audio mixer with limiter, one 12-bit DAC code per input word.
// Input channel: i_valid / o_ready carry i_mode, i_sample_a, i_sample_b.
// Output channel: o_valid / i_ready carry o_dac_code.
// Mode 0 offsets i_sample_a to unsigned and keeps its top 12 bits.
// Mode 1 sums both samples through a limiter whose Q1.16 gain drops on
// overload and recovers by 1/32 of the gap per mixed word.
// Controller steps from the accepting edge to the edge that raises o_valid:
//   mode 0: check, done
//   mode 1 without a gain update: check, multiply, low test, recover, done
//   mode 1 with a gain update: the same plus one pass of a restoring divider,
//   one quotient bit per cycle
// One word is in flight at a time. The next word is accepted in the cycle
// after the result is loaded into the output register, so it overlaps a
// result still waiting to be taken.
// A stalled receiver holds the output register; a finished word then waits
// until that register frees up, and o_ready stays low meanwhile.
// Reset clears the output valid, returns the controller to idle and sets
// the limiter gain to 1.0.
module two_stream_audio_mixer_limiter_top
    import tsaml_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_mode,
    input  logic signed [SAMPLE_W-1:0] i_sample_a,
    input  logic signed [SAMPLE_W-1:0] i_sample_b,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [CODE_W-1:0]          o_dac_code
);

    t_cmd  cmd;
    t_stat stat;

    tsaml_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tsaml_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_mode     (i_mode),
        .i_sample_a (i_sample_a),
        .i_sample_b (i_sample_b),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_dac_code (o_dac_code)
    );

endmodule
